// ----- rtl/fpsa_pkg.sv -----
// Package: shared types, constants and codes of the segment allocator.
`default_nettype none
package fpsa_pkg;

  localparam int MAX_SEG = 32;
  localparam int IDX_W   = $clog2(MAX_SEG);
  localparam int CNT_W   = $clog2(MAX_SEG + 1);
  localparam int ADDR_W  = 20;
  localparam int SIZE_W  = 21;
  localparam int OWN_W   = 8;

  localparam logic [SIZE_W-1:0] MEM_BYTES = SIZE_W'(1048576);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(MAX_SEG - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_SEG);

  // opcodes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_FIT   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // placement rules (anything else acts as first fit)
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [OWN_W-1:0]  owner_id;
    logic [SIZE_W-1:0] request_size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] freed_bytes;
    logic [SIZE_W-1:0] free_total;
  } out_word_t;

  // one segment table entry
  typedef struct packed {
    logic              valid;
    logic              used;
    logic [OWN_W-1:0]  owner;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } seg_t;

  typedef enum logic [2:0] {
    COP_HOLD,
    COP_ROTATE,
    COP_SQUEEZE,
    COP_ALLOC,
    COP_WRITE
  } cell_op_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  sel;
    logic              split;
    logic [SIZE_W-1:0] req;
    logic [OWN_W-1:0]  owner;
    seg_t              ins;
    seg_t              tail;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_PASS,
    S_FIXUP,
    S_SQUEEZE,
    S_CTAIL,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/fpsa_cell.sv -----
// One cell of the segment chain: holds a single table entry.
`default_nettype none
module fpsa_cell
  import fpsa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire cell_cmd_t        cmd,
  input  wire seg_t             left_seg,
  input  wire seg_t             right_seg,
  input  wire logic             hole_in,
  output seg_t                  seg,
  output logic                  hole_out
);

  seg_t seg_r, seg_nxt;
  seg_t rst_seg;
  logic [CNT_W-1:0] idx_ext, sel_ext;

  assign idx_ext  = CNT_W'(cell_idx);
  assign sel_ext  = CNT_W'(cmd.sel);
  assign seg      = seg_r;
  // an empty slot here or anywhere to the left
  assign hole_out = hole_in | ~seg_r.valid;

  // reset entry: the first cell covers all memory, the rest are empty
  always_comb begin
    rst_seg = '0;
    if (cell_idx == '0) begin
      rst_seg.valid = 1'b1;
      rst_seg.size  = MEM_BYTES;
    end
  end

  // next entry per broadcast command
  always_comb begin
    seg_nxt = seg_r;
    case (cmd.op)
      COP_ROTATE: seg_nxt = right_seg;
      COP_SQUEEZE: begin
        if (hole_out) seg_nxt = right_seg;
      end
      COP_ALLOC: begin
        if (idx_ext == sel_ext) begin
          seg_nxt.used  = 1'b1;
          seg_nxt.owner = cmd.owner;
          if (cmd.split) seg_nxt.size = cmd.req;
        end else if (cmd.split && idx_ext == sel_ext + CNT_W'(1)) begin
          seg_nxt = cmd.ins;
        end else if (cmd.split && idx_ext > sel_ext + CNT_W'(1)) begin
          seg_nxt = left_seg;
        end
      end
      COP_WRITE: begin
        if (idx_ext == sel_ext) seg_nxt = cmd.ins;
      end
      default: seg_nxt = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= rst_seg;
    end else begin
      seg_r <= seg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fpsa_ctrl.sv -----
// Sequencer: scans the rotating chain, filters passes and issues cell commands.
`default_nettype none
module fpsa_ctrl
  import fpsa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire in_word_t in_data,
  output logic       busy,
  output logic       out_strobe,
  output out_word_t  out_data,
  input  wire logic  cfg_valid,
  input  wire logic [1:0] cfg_data,
  input  wire seg_t  head,
  output cell_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              last;
  logic [1:0]        policy_r;
  in_word_t          item_r, item_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SIZE_W-1:0] freed_r, freed_nxt;
  logic [SIZE_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  wcnt_r, wcnt_nxt;
  logic [SIZE_W-1:0] at_r, at_nxt;
  seg_t              pd_r, pd_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;
  logic [SIZE_W-1:0] psize_r, psize_nxt;
  logic [ADDR_W-1:0] pstart_r, pstart_nxt;
  seg_t              e2;
  logic              cand, merge, split;

  assign last = (k_r == IDX_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.opcode == OP_ALLOC)
            state_nxt = (in_data.request_size == '0) ? S_DONE : S_SEARCH;
          else if (in_data.opcode == OP_FREE || in_data.opcode == OP_COMPACT)
            state_nxt = S_PASS;
          else
            state_nxt = S_DONE;
        end
      end
      S_SEARCH:  if (last) state_nxt = S_APPLY;
      S_APPLY:   state_nxt = S_DONE;
      S_PASS:    if (last) state_nxt = S_FIXUP;
      S_FIXUP:   state_nxt = S_SQUEEZE;
      S_SQUEEZE: begin
        if (last) state_nxt = (item_r.opcode == OP_COMPACT) ? S_CTAIL : S_DONE;
      end
      S_CTAIL:   state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy       = (state_r != S_IDLE);
    out_strobe = (state_r == S_DONE);
    out_data   = '{status: status_r, address: addr_r, freed_bytes: freed_r,
                   free_total: free_r};
  end

  // datapath and cell commands
  always_comb begin
    item_nxt   = item_r;
    status_nxt = status_r;
    addr_nxt   = addr_r;
    freed_nxt  = freed_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    wcnt_nxt   = wcnt_r;
    at_nxt     = at_r;
    pd_nxt     = pd_r;
    found_nxt  = found_r;
    pick_nxt   = pick_r;
    psize_nxt  = psize_r;
    pstart_nxt = pstart_r;
    k_nxt      = (state_r == S_SEARCH || state_r == S_PASS || state_r == S_SQUEEZE)
                 ? k_r + IDX_W'(1) : '0;
    cmd        = '{op: COP_HOLD, sel: '0, split: 1'b0, req: item_r.request_size,
                   owner: item_r.owner_id, ins: '0, tail: '0};
    e2         = '0;
    merge      = 1'b0;
    cand       = head.valid && !head.used && head.size >= item_r.request_size;
    split      = psize_r > item_r.request_size;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt   = in_data;
          status_nxt = (in_data.opcode == OP_ALLOC && in_data.request_size == '0)
                       ? ST_BAD_SIZE : ST_OK;
          addr_nxt   = '0;
          freed_nxt  = '0;
          wcnt_nxt   = '0;
          at_nxt     = '0;
          pd_nxt     = '0;
          found_nxt  = 1'b0;
        end
      end

      // fit search while the chain turns once
      S_SEARCH: begin
        cmd.op   = COP_ROTATE;
        cmd.tail = head;
        if (cand && (!found_r
            || (policy_r == POL_BEST && head.size < psize_r)
            || (policy_r == POL_WORST && head.size > psize_r))) begin
          found_nxt  = 1'b1;
          pick_nxt   = k_r;
          psize_nxt  = head.size;
          pstart_nxt = head.start;
        end
      end

      S_APPLY: begin
        if (!found_r) begin
          status_nxt = ST_NO_FIT;
        end else if (split && count_r == CNT_FULL) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.op    = COP_ALLOC;
          cmd.sel   = pick_r;
          cmd.split = split;
          cmd.ins   = '{valid: 1'b1, used: 1'b0, owner: '0,
                        start: pstart_r + item_r.request_size[ADDR_W-1:0],
                        size: psize_r - item_r.request_size};
          addr_nxt  = pstart_r;
          free_nxt  = free_r - item_r.request_size;
          if (split) count_nxt = count_r + CNT_W'(1);
        end
      end

      // filter pass: release or pack, one held word of lag
      S_PASS: begin
        cmd.op = COP_ROTATE;
        if (item_r.opcode == OP_FREE) begin
          e2 = head;
          if (head.valid && head.used && head.owner == item_r.owner_id) begin
            e2.used   = 1'b0;
            freed_nxt = freed_r + head.size;
          end
          merge = pd_r.valid && !pd_r.used && e2.valid && !e2.used;
        end else if (head.valid && head.used) begin
          e2       = head;
          e2.start = at_r[ADDR_W-1:0];
          at_nxt   = at_r + head.size;
        end
        if (merge) begin
          pd_nxt.size = pd_r.size + e2.size;
          cmd.tail    = '0;
        end else begin
          cmd.tail = pd_r;
          pd_nxt   = e2;
          wcnt_nxt = wcnt_r + CNT_W'(pd_r.valid);
        end
      end

      S_FIXUP: begin
        cmd.op    = COP_ROTATE;
        cmd.tail  = pd_r;
        count_nxt = wcnt_r + CNT_W'(pd_r.valid);
        if (item_r.opcode == OP_FREE) free_nxt = free_r + freed_r;
      end

      S_SQUEEZE: cmd.op = COP_SQUEEZE;

      // free tail after packing
      S_CTAIL: begin
        if (at_r < MEM_BYTES && count_r < CNT_FULL) begin
          cmd.op    = COP_WRITE;
          cmd.sel   = count_r[IDX_W-1:0];
          cmd.ins   = '{valid: 1'b1, used: 1'b0, owner: '0,
                        start: at_r[ADDR_W-1:0], size: MEM_BYTES - at_r};
          count_nxt = count_r + CNT_W'(1);
        end
      end

      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      k_r      <= '0;
      policy_r <= '0;
      free_r   <= MEM_BYTES;
      count_r  <= CNT_W'(1);
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
      if (cfg_valid) policy_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    status_r <= status_nxt;
    addr_r   <= addr_nxt;
    freed_r  <= freed_nxt;
    wcnt_r   <= wcnt_nxt;
    at_r     <= at_nxt;
    pd_r     <= pd_nxt;
    found_r  <= found_nxt;
    pick_r   <= pick_nxt;
    psize_r  <= psize_nxt;
    pstart_r <= pstart_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/fit_policy_segment_allocator_core.sv -----
// Top level: segment allocator built from a chain of table cells and a sequencer.
//
//  channel  ports                         word        handshake
//  input    start, busy, in_data          in_word_t   start & !busy
//  result   out_strobe, out_data          out_word_t  one-cycle strobe
//  config   cfg_valid, cfg_ready, cfg_data  2 bits    valid & ready
//
// Allocate: idle, a search pass over the chain, apply, then the result (a zero size
// or the unused opcode goes from idle straight to the result).
// Free and compact: idle, filter pass, fixup, squeeze pass (+ tail for compact), result.
// Each pass turns the chain once, one cell a cycle. Results are never stalled.
// Synchronous active-low reset leaves one free segment over all memory.
// Config is to be written only while idle; the block does not enforce this.
`default_nettype none
module fit_policy_segment_allocator_core
  import fpsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_data,
  output logic          out_strobe,
  output out_word_t     out_data,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [1:0] cfg_data
);

  cell_cmd_t cmd;
  seg_t      segs  [MAX_SEG];
  logic      holes [MAX_SEG];

  assign cfg_ready = 1'b1;

  fpsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .head       (segs[0]),
    .cmd        (cmd)
  );

  // row of cells, each wired to its neighbors
  for (genvar i = 0; i < MAX_SEG; i++) begin : g_cell
    seg_t left_seg, right_seg;
    logic hole_in;
    if (i == 0) begin : g_first
      assign left_seg = '0;
      assign hole_in  = 1'b0;
    end else begin : g_mid
      assign left_seg = segs[i-1];
      assign hole_in  = holes[i-1];
    end
    if (i == MAX_SEG - 1) begin : g_last
      assign right_seg = cmd.tail;
    end else begin : g_inner
      assign right_seg = segs[i+1];
    end
    fpsa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(i)),
      .cmd       (cmd),
      .left_seg  (left_seg),
      .right_seg (right_seg),
      .hole_in   (hole_in),
      .seg       (segs[i]),
      .hole_out  (holes[i])
    );
  end

endmodule
`default_nettype wire
